// ===== design/arc_pkg.sv =====
// Package for the ARP responder with cache: word types, scan token, table write,
// status codes and protocol constants. No dependencies.
package arc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int IDX_W             = 8;

    localparam logic [1:0]  REQ_FRAME    = 2'd0;
    localparam logic [1:0]  REQ_RESOLVE  = 2'd1;
    localparam logic [1:0]  REQ_LOOKUP   = 2'd2;

    localparam logic [10:0] MIN_FRAME_LEN = 11'd28;
    localparam logic [15:0] HW_ETHERNET   = 16'h0001;
    localparam logic [15:0] PROTO_IPV4    = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN   = 8'd6;
    localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
    localparam logic [15:0] OP_REQUEST    = 16'd1;
    localparam logic [15:0] OP_REPLY      = 16'd2;

    localparam logic [1:0]  FRAME_OP_REQUEST = 2'd1;
    localparam logic [1:0]  FRAME_OP_REPLY   = 2'd2;

    localparam logic        CFG_OWN_MAC = 1'b0;
    localparam logic        CFG_OWN_IP  = 1'b1;

    typedef enum logic [3:0] {
        ST_IGNORED   = 4'd0,
        ST_REPLIED   = 4'd1,
        ST_LEARNED   = 4'd2,
        ST_UNEXPECT  = 4'd3,
        ST_REQ_NEW   = 4'd4,
        ST_REQ_PEND  = 4'd5,
        ST_RESOLVED  = 4'd6,
        ST_FULL      = 4'd7,
        ST_HIT       = 4'd8,
        ST_MISS      = 4'd9
    } arc_status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } arc_fsm_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] frame_length;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_addr_len;
        logic [7:0]  proto_addr_len;
        logic [15:0] operation;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [47:0] target_mac;
        logic [31:0] query_ip;
    } arc_in_t;

    typedef struct packed {
        arc_status_t status;
        logic        send_frame;
        logic [1:0]  frame_oper;
        logic [47:0] frame_target_mac;
        logic [31:0] frame_target_ip;
        logic [47:0] found_mac;
        logic        unqueue;
    } arc_out_t;

    // token walking the cell chain
    typedef struct packed {
        logic             valid;
        logic [31:0]      ip;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             hit_wait;
        logic [47:0]      hit_mac;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } arc_tok_t;

    // table update broadcast to all cells
    typedef struct packed {
        logic             en;
        logic             alloc;
        logic [IDX_W-1:0] idx;
        logic [31:0]      ip;
        logic [47:0]      mac;
    } arc_wr_t;

endpackage

// ===== design/arc_cell.sv =====
// One cache slot: holds used/waiting/ip/mac and passes the scan token on.
// Depends on arc_pkg.
module arc_cell #(
    parameter logic [arc_pkg::IDX_W-1:0] INDEX = '0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  arc_pkg::arc_tok_t tok_in,
    input  arc_pkg::arc_wr_t  wr,
    output arc_pkg::arc_tok_t tok_out
);
    import arc_pkg::*;

    logic        used_reg;
    logic        waiting_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    arc_tok_t    tok_reg;
    arc_tok_t    tok_next;
    logic        sel;

    assign sel = wr.en && (wr.idx == INDEX);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.hit && used_reg && (ip_reg == tok_in.ip))
        begin
            tok_next.hit      = 1'b1;
            tok_next.hit_idx  = INDEX;
            tok_next.hit_wait = waiting_reg;
            tok_next.hit_mac  = mac_reg;
        end
        if (tok_in.valid && !tok_in.free && !used_reg)
        begin
            tok_next.free     = 1'b1;
            tok_next.free_idx = INDEX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= 1'b0;
            waiting_reg <= 1'b0;
            tok_reg     <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (sel)
            begin
                if (wr.alloc)
                begin
                    used_reg    <= 1'b1;
                    waiting_reg <= 1'b1;
                end
                else
                begin
                    waiting_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            if (wr.alloc)
            begin
                ip_reg  <= wr.ip;
                mac_reg <= '0;
            end
            else
            begin
                mac_reg <= wr.mac;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/arc_ctrl.sv =====
// Sequencer: takes an input word, launches a scan down the cell chain,
// decides the result and table update, holds the output word. Depends on arc_pkg.
module arc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  arc_pkg::arc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output arc_pkg::arc_out_t out_data,
    input  logic [47:0]       own_mac,
    output arc_pkg::arc_tok_t tok_launch,
    input  arc_pkg::arc_tok_t tok_return,
    output arc_pkg::arc_wr_t  wr
);
    import arc_pkg::*;

    arc_fsm_t state_reg, state_next;
    arc_in_t  in_reg;
    arc_tok_t res_reg;
    arc_tok_t launch_reg, launch_next;
    logic     out_valid_reg, out_valid_next;
    arc_out_t out_reg, out_res;
    logic     accept, load;
    logic     frame_ok_in, need_scan;
    logic     frame_ok, hit_res;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == FSM_IDLE);

    assign frame_ok_in = (in_data.frame_length >= MIN_FRAME_LEN)
                      && (in_data.hw_type == HW_ETHERNET)
                      && (in_data.proto_type == PROTO_IPV4)
                      && (in_data.hw_addr_len == HW_ADDR_LEN)
                      && (in_data.proto_addr_len == PROTO_ADDR_LEN);

    assign need_scan = (in_data.req_type == REQ_RESOLVE)
                    || (in_data.req_type == REQ_LOOKUP)
                    || ((in_data.req_type == REQ_FRAME) && frame_ok_in
                        && (in_data.operation == OP_REPLY)
                        && (in_data.target_mac == own_mac));

    assign frame_ok = (in_reg.frame_length >= MIN_FRAME_LEN)
                   && (in_reg.hw_type == HW_ETHERNET)
                   && (in_reg.proto_type == PROTO_IPV4)
                   && (in_reg.hw_addr_len == HW_ADDR_LEN)
                   && (in_reg.proto_addr_len == PROTO_ADDR_LEN);

    assign hit_res = res_reg.hit && !res_reg.hit_wait;

    // result and table update for the item held in in_reg
    always_comb
    begin
        out_res  = '0;
        out_res.status = ST_IGNORED;
        wr       = '0;
        wr.ip    = in_reg.query_ip;
        wr.mac   = in_reg.sender_mac;
        case (in_reg.req_type)
            REQ_FRAME:
            begin
                if (frame_ok && (in_reg.operation == OP_REQUEST))
                begin
                    out_res.status           = ST_REPLIED;
                    out_res.send_frame       = 1'b1;
                    out_res.frame_oper       = FRAME_OP_REPLY;
                    out_res.frame_target_mac = in_reg.sender_mac;
                    out_res.frame_target_ip  = in_reg.sender_ip;
                end
                else if (frame_ok && (in_reg.operation == OP_REPLY)
                         && (in_reg.target_mac == own_mac))
                begin
                    if (res_reg.hit && res_reg.hit_wait)
                    begin
                        out_res.status  = ST_LEARNED;
                        out_res.unqueue = 1'b1;
                        wr.en    = 1'b1;
                        wr.alloc = 1'b0;
                        wr.idx   = res_reg.hit_idx;
                    end
                    else
                    begin
                        out_res.status = ST_UNEXPECT;
                    end
                end
            end
            REQ_RESOLVE:
            begin
                if (hit_res)
                begin
                    out_res.status = ST_RESOLVED;
                end
                else if (res_reg.hit || res_reg.free)
                begin
                    out_res.status          = res_reg.hit ? ST_REQ_PEND : ST_REQ_NEW;
                    out_res.send_frame      = 1'b1;
                    out_res.frame_oper      = FRAME_OP_REQUEST;
                    out_res.frame_target_ip = in_reg.query_ip;
                    if (!res_reg.hit)
                    begin
                        wr.en    = 1'b1;
                        wr.alloc = 1'b1;
                        wr.idx   = res_reg.free_idx;
                    end
                end
                else
                begin
                    out_res.status = ST_FULL;
                end
            end
            REQ_LOOKUP:
            begin
                if (hit_res)
                begin
                    out_res.status    = ST_HIT;
                    out_res.found_mac = res_reg.hit_mac;
                end
                else
                begin
                    out_res.status = ST_MISS;
                end
            end
            default:
            begin
                out_res.status = ST_IGNORED;
            end
        endcase
        if (!load)
        begin
            wr.en = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        load           = 1'b0;
        launch_next    = '0;
        launch_next.ip = (in_data.req_type == REQ_FRAME) ? in_data.sender_ip
                                                         : in_data.query_ip;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    if (need_scan)
                    begin
                        launch_next.valid = 1'b1;
                        state_next        = FSM_SCAN;
                    end
                    else
                    begin
                        state_next = FSM_DONE;
                    end
                end
            end
            FSM_SCAN:
            begin
                if (tok_return.valid)
                begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load       = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            out_valid_reg <= 1'b0;
            launch_reg    <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            launch_reg    <= launch_next;
            if (accept)
            begin
                res_reg <= '0;
            end
            else if (state_reg == FSM_SCAN && tok_return.valid)
            begin
                res_reg <= tok_return;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= in_data;
        end
        if (load)
        begin
            out_reg <= out_res;
        end
    end

    assign tok_launch = launch_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

endmodule

// ===== design/arp_responder_with_cache.sv =====
// Top level of the ARP responder with cache: APB registers, cell chain, sequencer.
// Depends on arc_pkg, arc_cell, arc_ctrl.
//
//  port group        dir   handshake           word
//  in_*              in    in_valid/in_ready   arc_in_t
//  out_*             out   out_valid/out_ready arc_out_t
//  p*                in/out APB, pready tied 1  own_mac @0x0, own_ip @0x8
//
// An item that scans the table sends its token down the cell chain, which steps
// through one cell per cycle; frames that need no table access skip the scan.
// One item is in flight at a time; a result held by out_ready low holds off
// the next item only at its finish step.
// Reset clears the table at once; no clearing pass.
module arp_responder_with_cache #(
    parameter int TABLE_ENTRIES = arc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  arc_pkg::arc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output arc_pkg::arc_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import arc_pkg::*;

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic        cfg_wr;
    arc_tok_t    chain [TABLE_ENTRIES+1];
    arc_wr_t     wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == CFG_OWN_MAC)
            begin
                own_mac_reg <= pwdata[47:0];
            end
            else
            begin
                own_ip_reg <= pwdata[31:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[3] == CFG_OWN_MAC)
        begin
            prdata = {16'd0, own_mac_reg};
        end
        else
        begin
            prdata = {32'd0, own_ip_reg};
        end
    end

    arc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .own_mac    (own_mac_reg),
        .tok_launch (chain[0]),
        .tok_return (chain[TABLE_ENTRIES]),
        .wr         (wr)
    );

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        arc_cell #(
            .INDEX (IDX_W'(i))
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .wr      (wr),
            .tok_out (chain[i+1])
        );
    end

endmodule
